// ===== design/sle_pkg.sv =====
// Shared types, codes and character constants for the serial line editor.
// No dependencies; every module of the block imports this package.
package sle_pkg;

  localparam int SLE_BUF_DEPTH = 64;
  localparam bit SLE_ECHO_RESET = 1'b1;

  localparam logic [7:0] TOGGLE_RESET = 8'd27;

  localparam logic [7:0] CH_ENTER = 8'd13;
  localparam logic [7:0] CH_BACK  = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_F     = 8'h46;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] ST_EDIT  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  localparam logic REG_TOGGLE = 1'b0;

  typedef enum logic [1:0] {
    MSG_NONE = 2'd0,
    MSG_ON   = 2'd1,
    MSG_OFF  = 2'd2
  } msg_e;

  typedef enum logic [2:0] {
    TAIL_NONE    = 3'd0,
    TAIL_CHAR    = 3'd1,
    TAIL_ERASE   = 3'd2,
    TAIL_NL      = 3'd3,
    TAIL_BANG    = 3'd4,
    TAIL_BANG_NL = 3'd5,
    TAIL_DOT     = 3'd6,
    TAIL_DOT_NL  = 3'd7
  } tail_e;

  typedef struct packed {
    msg_e        msg;
    tail_e       tail;
    logic [7:0]  ch;
    logic [7:0]  rd_byte;
    logic [1:0]  status;
    logic        echo;
  } desc_t;

endpackage

// ===== design/sle_editor.sv =====
// Line editing state, line buffer memory and per-request transmit descriptor.
// Depends on sle_pkg; feeds sle_emitter through a one-entry descriptor register.
module sle_editor import sle_pkg::*; #(
  parameter int BUF_DEPTH  = SLE_BUF_DEPTH,
  parameter bit ECHO_RESET = SLE_ECHO_RESET
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [5:0]  read_index_i,
  input  logic [7:0]  toggle_byte_i,
  output logic        desc_valid_o,
  input  logic        desc_ready_i,
  output desc_t       desc_o
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [7:0] DEPTH_B = 8'(BUF_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_DEPTH - 1);

  logic [7:0]    line_mem_q [BUF_DEPTH];
  logic [7:0]    wp_q, wp_d;
  logic          echo_q, echo_d;
  logic [1:0]    status_q, status_d;
  msg_e          msg_d;
  tail_e         tail_d;
  logic          desc_valid_q;
  desc_t         desc_q;
  logic [7:0]    rd_data_q;
  logic          rd_zero_q;
  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_ext;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;

  assign req_ready_o = !desc_valid_q || desc_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign rd_ext      = {2'b00, read_index_i};
  assign rd_addr     = rd_ext[AW-1:0];
  assign rd_in_range = rd_ext < DEPTH_B;

  always_comb begin
    wp_d     = wp_q;
    echo_d   = echo_q;
    status_d = status_q;
    msg_d    = MSG_NONE;
    tail_d   = TAIL_NONE;
    wr_en    = 1'b0;
    wr_addr  = wp_q[AW-1:0];
    wr_data  = rx_byte_i;
    case (kind_i)
      KIND_BYTE: begin
        if (wp_q == 8'd0 && rx_byte_i == toggle_byte_i) begin
          echo_d = !echo_q;
          msg_d  = echo_d ? MSG_ON : MSG_OFF;
        end
        if (status_q != ST_EDIT) begin
          tail_d = echo_d ? TAIL_BANG_NL : TAIL_BANG;
        end else if (wp_q < DEPTH_B) begin
          if (rx_byte_i == CH_ENTER) begin
            wr_en    = 1'b1;
            wr_data  = 8'd0;
            wp_d     = 8'd0;
            status_d = ST_READY;
            tail_d   = echo_d ? TAIL_NL : TAIL_NONE;
          end else if (rx_byte_i == CH_BACK) begin
            if (wp_q != 8'd0) begin
              wp_d = wp_q - 8'd1;
            end
            tail_d = echo_d ? TAIL_ERASE : TAIL_NONE;
          end else begin
            wr_en  = 1'b1;
            wp_d   = wp_q + 8'd1;
            tail_d = echo_d ? TAIL_CHAR : TAIL_NONE;
          end
        end else begin
          if (rx_byte_i == CH_BACK) begin
            wp_d   = wp_q - 8'd1;
            tail_d = echo_d ? TAIL_ERASE : TAIL_NONE;
          end else begin
            if (wp_q != 8'hFF) begin
              wp_d = wp_q + 8'd1;
            end
            tail_d = echo_d ? TAIL_DOT : TAIL_NONE;
            if (rx_byte_i == CH_ENTER) begin
              tail_d   = echo_d ? TAIL_DOT_NL : TAIL_NONE;
              wr_en    = 1'b1;
              wr_addr  = LAST_ADDR;
              wr_data  = 8'd0;
              wp_d     = 8'd0;
              status_d = ST_LONG;
            end
          end
        end
      end
      KIND_RELEASE: begin
        status_d = ST_EDIT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= 8'd0;
      echo_q       <= ECHO_RESET;
      status_q     <= ST_EDIT;
      desc_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wp_q         <= wp_d;
        echo_q       <= echo_d;
        status_q     <= status_d;
        desc_valid_q <= 1'b1;
      end else if (desc_ready_i) begin
        desc_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q.msg     <= msg_d;
      desc_q.tail    <= tail_d;
      desc_q.ch      <= rx_byte_i;
      desc_q.rd_byte <= 8'd0;
      desc_q.status  <= status_d;
      desc_q.echo    <= echo_d;
      rd_zero_q      <= !(kind_i == KIND_READ && rd_in_range);
    end
    if (accept && wr_en) begin
      line_mem_q[wr_addr] <= wr_data;
    end
    if (accept && kind_i == KIND_READ) begin
      rd_data_q <= line_mem_q[rd_addr];
    end
  end

  always_comb begin
    desc_o         = desc_q;
    desc_o.rd_byte = rd_zero_q ? 8'd0 : rd_data_q;
  end

  assign desc_valid_o = desc_valid_q;

endmodule

// ===== design/sle_emitter.sv =====
// Walks a transmit descriptor into result items, one per unstalled cycle.
// Depends on sle_pkg; drives the output register of the result stream.
module sle_emitter import sle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       desc_valid_i,
  output logic       desc_ready_o,
  input  desc_t      desc_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_present_o,
  output logic [7:0] tx_char_o,
  output logic [7:0] read_byte_o,
  output logic [1:0] line_status_o,
  output logic       echo_on_o,
  output logic       last_o
);

  function automatic logic [7:0] msg_char(input logic off, input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = CH_E;
      4'd1:    c = CH_C;
      4'd2:    c = CH_H;
      4'd3:    c = CH_O;
      4'd4:    c = CH_SPACE;
      4'd5:    c = CH_O;
      4'd6:    c = off ? CH_F : CH_N;
      4'd7:    c = off ? CH_F : CH_LF;
      4'd8:    c = off ? CH_LF : CH_ENTER;
      default: c = CH_ENTER;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tail_char(input tail_e t, input logic [7:0] ch,
                                           input logic [3:0] j);
    logic [7:0] c;
    case (t)
      TAIL_CHAR:    c = ch;
      TAIL_ERASE:   c = (j == 4'd1) ? CH_SPACE : CH_BACK;
      TAIL_NL:      c = (j == 4'd0) ? CH_LF : CH_ENTER;
      TAIL_BANG:    c = CH_BANG;
      TAIL_BANG_NL: c = (j == 4'd0) ? CH_BANG : ((j == 4'd1) ? CH_LF : CH_ENTER);
      TAIL_DOT:     c = CH_DOT;
      TAIL_DOT_NL:  c = (j == 4'd0) ? CH_DOT : ((j == 4'd1) ? CH_LF : CH_ENTER);
      default:      c = 8'd0;
    endcase
    return c;
  endfunction

  logic [3:0] step_q;
  logic [3:0] msg_len;
  logic [3:0] tail_len;
  logic [3:0] total;
  logic       is_last;
  logic       load;
  logic [7:0] cur_char;
  logic       out_valid_q;
  logic       tx_present_q;
  logic [7:0] tx_char_q;
  logic [7:0] read_byte_q;
  logic [1:0] status_q;
  logic       echo_q;
  logic       last_q;

  always_comb begin
    case (desc_i.msg)
      MSG_ON:  msg_len = 4'd9;
      MSG_OFF: msg_len = 4'd10;
      default: msg_len = 4'd0;
    endcase
    case (desc_i.tail)
      TAIL_CHAR, TAIL_BANG, TAIL_DOT:            tail_len = 4'd1;
      TAIL_NL:                                   tail_len = 4'd2;
      TAIL_ERASE, TAIL_BANG_NL, TAIL_DOT_NL:     tail_len = 4'd3;
      default:                                   tail_len = 4'd0;
    endcase
  end

  assign total    = msg_len + tail_len;
  assign is_last  = (total == 4'd0) || (step_q == total - 4'd1);
  assign cur_char = (step_q < msg_len) ?
                    msg_char(desc_i.msg == MSG_OFF, step_q) :
                    tail_char(desc_i.tail, desc_i.ch, step_q - msg_len);

  assign load         = !out_valid_q || out_ready_i;
  assign desc_ready_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 4'd0;
    end else if (load) begin
      out_valid_q <= desc_valid_i;
      if (desc_valid_i) begin
        step_q <= is_last ? 4'd0 : step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && desc_valid_i) begin
      tx_present_q <= (total != 4'd0);
      tx_char_q    <= (total != 4'd0) ? cur_char : 8'd0;
      read_byte_q  <= desc_i.rd_byte;
      status_q     <= desc_i.status;
      echo_q       <= desc_i.echo;
      last_q       <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_present_o  = tx_present_q;
  assign tx_char_o     = tx_char_q;
  assign read_byte_o   = read_byte_q;
  assign line_status_o = status_q;
  assign echo_on_o     = echo_q;
  assign last_o        = last_q;

endmodule

// ===== design/serial_line_editor.sv =====
// Top level of the serial console line editor: stream ports, APB register.
// Depends on sle_pkg, sle_editor and sle_emitter.
//
// Requests enter on the s_axis channel: tuser carries the kind (received
// byte, release line, read buffer entry), tdata the received byte and the
// read index. Results leave on the m_axis channel, one run per request;
// tlast marks the final result of a run and tuser flags a transmit char.
// A request is taken into a one-entry descriptor register at its accept
// edge, where the line state and buffer are updated; its first result is
// loaded from the descriptor into the output register. While m_axis is
// not stalled the emitter gives one result per cycle: 1 for a request
// that sends nothing, up to 12 for a toggle byte that turns echo on
// followed by a pending-line answer, so a request occupies the emitter
// until its last result is loaded and the next request is accepted in
// the cycle its predecessor's last result is loaded.
// A stalled m_axis holds the output register and, behind it, the
// descriptor, which back-pressures s_axis. Reset clears the write
// position, line status and valid flags, sets echo to ECHO_RESET and the
// toggle byte to 27; buffer contents stay undefined until written.
module serial_line_editor import sle_pkg::*; #(
  parameter int BUF_DEPTH  = SLE_BUF_DEPTH,
  parameter bit ECHO_RESET = SLE_ECHO_RESET
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], read_index[13:8], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tx_char[7:0], read_byte[15:8],
                                     // line_status[17:16], echo_on[18], zero pad
  output logic [0:0]  m_axis_tuser,  // tx_present[0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] toggle_q;
  logic       desc_valid;
  logic       desc_ready;
  desc_t      desc;
  logic       tx_present;
  logic [7:0] tx_char;
  logic [7:0] read_byte;
  logic [1:0] line_status;
  logic       echo_on;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOGGLE) ? {24'd0, toggle_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= TOGGLE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOGGLE) begin
      toggle_q <= pwdata[7:0];
    end
  end

  sle_editor #(
    .BUF_DEPTH  (BUF_DEPTH),
    .ECHO_RESET (ECHO_RESET)
  ) u_editor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .kind_i        (s_axis_tuser),
    .rx_byte_i     (s_axis_tdata[7:0]),
    .read_index_i  (s_axis_tdata[13:8]),
    .toggle_byte_i (toggle_q),
    .desc_valid_o  (desc_valid),
    .desc_ready_i  (desc_ready),
    .desc_o        (desc)
  );

  sle_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_valid_i  (desc_valid),
    .desc_ready_o  (desc_ready),
    .desc_i        (desc),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .tx_present_o  (tx_present),
    .tx_char_o     (tx_char),
    .read_byte_o   (read_byte),
    .line_status_o (line_status),
    .echo_on_o     (echo_on),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, echo_on, line_status, read_byte, tx_char};
  assign m_axis_tuser = tx_present;

endmodule
